// ===== rtl/core/fhm_pkg.sv =====
// Shared widths, operation codes and status codes of the queued mutex.
package fhm_pkg;

    localparam int OP_W     = 2;
    localparam int TID_W    = 4;
    localparam int STATUS_W = 4;
    localparam int WAIT_W   = 5;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [TID_W-1:0]    tid_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [WAIT_W-1:0]   waiters_t;

    localparam op_t OP_LOCK    = 2'd0;
    localparam op_t OP_UNLOCK  = 2'd1;
    localparam op_t OP_TRYLOCK = 2'd2;

    localparam status_t ST_GRANTED   = 4'd0;
    localparam status_t ST_ALREADY   = 4'd1;
    localparam status_t ST_QUEUED    = 4'd2;
    localparam status_t ST_FULL      = 4'd3;
    localparam status_t ST_RELEASED  = 4'd4;
    localparam status_t ST_HANDOFF   = 4'd5;
    localparam status_t ST_NOTOWNER  = 4'd6;
    localparam status_t ST_TRYLOCKED = 4'd7;
    localparam status_t ST_TRYFREE   = 4'd8;

endpackage

// ===== rtl/core/fhm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fhm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/fifo_handoff_mutex.sv =====
// Queued mutex with direct handoff: top level with request decode and queue control.
//
// One request (lock, unlock, trylock) is accepted per beat and gives one result beat.
// On the accept cycle a request issues a read of the queue head from the wait-queue RAM;
// the request is then decided with that entry once the result register is free or being
// drained, and the result is written to it; no new request is taken before that. The wait
// queue holds THREAD_COUNT entries in a one-read, one-write RAM; head, tail, count, owner and
// lock flag sit in flip-flops and clear at reset, so no clearing pass is needed. A new
// request is taken while the previous result still waits on m_; it is held until m_
// frees up. Results carry the state after the request; waiters is the low five bits of
// the queue count.
module fifo_handoff_mutex #(
    parameter int THREAD_COUNT = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fhm_pkg::op_t      s_operation,
    input  fhm_pkg::tid_t     s_thread_id,
    output logic              m_valid,
    input  logic              m_ready,
    output fhm_pkg::status_t  m_status,
    output logic              m_owner_valid,
    output fhm_pkg::tid_t     m_owner_id,
    output fhm_pkg::waiters_t m_waiters
);
    import fhm_pkg::*;

    localparam int PTR_W = $clog2(THREAD_COUNT);
    localparam int CNT_W = $clog2(THREAD_COUNT + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic             state_reg, state_next;
    op_t              op_reg;
    tid_t             tid_reg;
    logic             locked_reg, locked_next;
    tid_t             owner_reg, owner_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             m_valid_reg, m_valid_next;
    status_t          status_reg, status_next;
    logic             owner_valid_reg;
    tid_t             owner_id_reg;
    waiters_t         waiters_reg;

    logic             accept;
    logic             go;
    logic             push;
    tid_t             head_data;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(THREAD_COUNT - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    // decide only when the result register is free or being drained
    assign go      = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);

    fhm_ram #(
        .WIDTH (TID_W),
        .DEPTH (THREAD_COUNT)
    ) u_wait_ram (
        .aclk    (aclk),
        .wr_en   (push),
        .wr_addr (tail_reg),
        .wr_data (tid_reg),
        .rd_en   (accept),
        .rd_addr (head_reg),
        .rd_data (head_data)
    );

    always_comb begin
        locked_next = locked_reg;
        owner_next  = owner_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = status_reg;
        push        = 1'b0;
        case (op_reg)
            OP_LOCK: begin
                if (!locked_reg) begin
                    locked_next = 1'b1;
                    owner_next  = tid_reg;
                    status_next = ST_GRANTED;
                end else if (owner_reg == tid_reg) begin
                    status_next = ST_ALREADY;
                end else if (count_reg == CNT_W'(THREAD_COUNT)) begin
                    status_next = ST_FULL;
                end else begin
                    push        = go;
                    tail_next   = wrap_inc(tail_reg);
                    count_next  = count_reg + CNT_W'(1);
                    status_next = ST_QUEUED;
                end
            end
            OP_UNLOCK: begin
                if (!locked_reg || owner_reg != tid_reg) begin
                    status_next = ST_NOTOWNER;
                end else if (count_reg != '0) begin
                    owner_next  = head_data;
                    head_next   = wrap_inc(head_reg);
                    count_next  = count_reg - CNT_W'(1);
                    status_next = ST_HANDOFF;
                end else begin
                    locked_next = 1'b0;
                    owner_next  = '0;
                    status_next = ST_RELEASED;
                end
            end
            default: begin
                // trylock, and the unused code acts the same
                status_next = locked_reg ? ST_TRYLOCKED : ST_TRYFREE;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        if (accept) begin
            state_next = S_EXEC;
        end else if (go) begin
            state_next = S_IDLE;
        end
        m_valid_next = m_valid_reg;
        if (go) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            locked_reg  <= 1'b0;
            owner_reg   <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (go) begin
                locked_reg <= locked_next;
                owner_reg  <= owner_next;
                head_reg   <= head_next;
                tail_reg   <= tail_next;
                count_reg  <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_operation;
            tid_reg <= s_thread_id;
        end
        if (go) begin
            status_reg      <= status_next;
            owner_valid_reg <= locked_next;
            owner_id_reg    <= locked_next ? owner_next : '0;
            waiters_reg     <= WAIT_W'(count_next);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_owner_valid = owner_valid_reg;
    assign m_owner_id    = owner_id_reg;
    assign m_waiters     = waiters_reg;

endmodule

// ===== tb/fhm_tb_pkg.sv =====
// Request tracker for the queued mutex: predicts each result beat and checks the DUT output.
package fhm_tb_pkg;

    import fhm_pkg::*;

    localparam int  THREADS  = 16;
    localparam op_t OP_SPARE = 2'd3;   // unused code, decodes as trylock

    typedef struct packed {
        status_t  status;
        logic     owner_valid;
        tid_t     owner_id;
        waiters_t waiters;
    } mutex_reply_t;

    class mutex_tracker;
        bit           locked;
        tid_t         owner;
        tid_t         wait_line[$];
        mutex_reply_t predicted_replies[$];
        int unsigned  checked;
        int unsigned  mismatches;
        int unsigned  peak_waiters;
        bit [15:0]    status_hit;

        function new();
            locked = 1'b0;
            owner  = '0;
        endfunction

        function int unsigned pending();
            return predicted_replies.size();
        endfunction

        // Apply one accepted request to the mutex state and queue its reply.
        function void note_request(op_t op, tid_t tid);
            mutex_reply_t reply;
            status_t      st;
            case (op)
                OP_LOCK: begin
                    if (!locked) begin
                        locked = 1'b1;
                        owner  = tid;
                        st     = ST_GRANTED;
                    end else if (owner == tid) begin
                        st = ST_ALREADY;
                    end else if (wait_line.size() >= THREADS) begin
                        st = ST_FULL;
                    end else begin
                        wait_line.push_back(tid);
                        st = ST_QUEUED;
                    end
                end
                OP_UNLOCK: begin
                    if (!locked || owner != tid) begin
                        st = ST_NOTOWNER;
                    end else if (wait_line.size() != 0) begin
                        owner = wait_line.pop_front();
                        st    = ST_HANDOFF;
                    end else begin
                        locked = 1'b0;
                        owner  = '0;
                        st     = ST_RELEASED;
                    end
                end
                default: st = locked ? ST_TRYLOCKED : ST_TRYFREE;
            endcase
            reply.status      = st;
            reply.owner_valid = locked;
            reply.owner_id    = locked ? owner : tid_t'(0);
            reply.waiters     = waiters_t'(wait_line.size());
            predicted_replies.push_back(reply);
            status_hit[st] = 1'b1;
            if (wait_line.size() > peak_waiters)
                peak_waiters = wait_line.size();
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH: %s", what);
        endfunction

        function void check_result(status_t st, logic ov, tid_t oid, waiters_t wt);
            mutex_reply_t want;
            checked++;
            if (predicted_replies.size() == 0) begin
                flag($sformatf("result beat with nothing outstanding: status %0d owner %0d/%0d waiters %0d",
                               st, ov, oid, wt));
                return;
            end
            want = predicted_replies.pop_front();
            if (st !== want.status || ov !== want.owner_valid ||
                oid !== want.owner_id || wt !== want.waiters)
                flag($sformatf("beat %0d: exp status %0d owner %0d/%0d waiters %0d, got %0d %0d/%0d %0d",
                               checked, want.status, want.owner_valid, want.owner_id,
                               want.waiters, st, ov, oid, wt));
        endfunction
    endclass

endpackage

// ===== tb/tb_fifo_handoff_mutex.sv =====
// Top-level testbench for the queued mutex: stimulus, back-pressure and result checking.
module tb_fifo_handoff_mutex;
    timeunit 1ns;
    timeprecision 1ps;

    import fhm_pkg::*;
    import fhm_tb_pkg::*;

    localparam int unsigned TOTAL_REQUESTS = 1450;
    localparam int unsigned LONG_HOLD      = 80;
    localparam int unsigned DRAIN_CYCLES   = 10;

    typedef enum int unsigned {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_NOISE} episode_t;

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    op_t      s_operation;
    tid_t     s_thread_id;
    logic     m_valid;
    logic     m_ready;
    status_t  m_status;
    logic     m_owner_valid;
    tid_t     m_owner_id;
    waiters_t m_waiters;

    mutex_tracker book = new();
    int unsigned  requests_sent;

    fifo_handoff_mutex #(.THREAD_COUNT(THREADS)) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_thread_id   (s_thread_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_owner_valid (m_owner_valid),
        .m_owner_id    (m_owner_id),
        .m_waiters     (m_waiters)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic offer_request(input op_t op, input tid_t tid);
        s_valid     <= 1'b1;
        s_operation <= op;
        s_thread_id <= tid;
        do @(posedge aclk); while (!s_ready);
        book.note_request(op, tid);
        requests_sent++;
    endtask

    task automatic pause_sender(input int unsigned cycles);
        if (cycles != 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // always spends at least one cycle so valid is never dropped and raised in one step
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (book.pending() != 0);
    endtask

    function automatic void pick_request(input episode_t mode, output op_t op, output tid_t tid);
        int unsigned r;
        bit          by_owner;
        r        = $urandom_range(0, 99);
        tid      = tid_t'($urandom_range(0, 15));
        by_owner = 1'b0;
        op       = OP_TRYLOCK;
        case (mode)
            MODE_FILL: begin
                if (r < 80)      op = OP_LOCK;
                else if (r < 88) op = OP_TRYLOCK;
                else begin
                    op       = OP_UNLOCK;
                    by_owner = 1'b1;
                end
            end
            MODE_DRAIN: begin
                if (r < 70) begin
                    op       = OP_UNLOCK;
                    by_owner = 1'b1;
                end else if (r < 80) op = OP_UNLOCK;
                else if (r < 95)     op = OP_LOCK;
                else                 op = OP_TRYLOCK;
            end
            MODE_MIXED: begin
                if (r < 35) op = OP_LOCK;
                else if (r < 65) begin
                    op       = OP_UNLOCK;
                    by_owner = 1'b1;
                end else if (r < 75) op = OP_UNLOCK;
                else if (r < 90)     op = OP_TRYLOCK;
                else                 op = OP_SPARE;
            end
            default: op = op_t'($urandom_range(0, 3));
        endcase
        if (by_owner && book.locked)
            tid = book.owner;
    endfunction

    initial begin : stimulus
        episode_t    mode;
        int unsigned ep_len;
        bit          burst;
        bit          paused;
        op_t         op;
        tid_t        tid;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_operation = OP_LOCK;
        s_thread_id = '0;
        paused      = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: every status but released, spare opcode, repeated waiter, full queue
        offer_request(OP_TRYLOCK, 4'd0);
        offer_request(OP_UNLOCK, 4'd3);      // unlock while free
        pause_sender(idle_len());
        offer_request(OP_LOCK, 4'd15);
        offer_request(OP_LOCK, 4'd15);
        offer_request(OP_SPARE, 4'd0);
        offer_request(OP_UNLOCK, 4'd0);      // not the owner
        for (int i = 0; i < 15; i++) begin
            offer_request(OP_LOCK, tid_t'(i));
            pause_sender(idle_len());
        end
        offer_request(OP_LOCK, 4'd3);        // second wait entry for thread 3
        offer_request(OP_LOCK, 4'd9);        // queue full
        offer_request(OP_UNLOCK, 4'd15);     // hand off to thread 0
        wait_drained();

        while (requests_sent < TOTAL_REQUESTS) begin
            mode   = episode_t'($urandom_range(0, 3));
            ep_len = $urandom_range(10, 60);
            burst  = ($urandom_range(0, 3) == 0);
            repeat (ep_len) begin
                pick_request(mode, op, tid);
                offer_request(op, tid);
                if (!burst)
                    pause_sender(idle_len());
            end
            if (!paused && requests_sent >= TOTAL_REQUESTS / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d requests driven, %0d result beats checked", requests_sent, book.checked);
        $display("%0d of 9 status codes produced, wait queue peaked at %0d",
                 $countones(book.status_hit), book.peak_waiters);
        if (book.mismatches == 0 && book.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : receiver
        int unsigned run_len;
        int unsigned stall_len;
        int unsigned holds_done;
        m_ready    = 1'b0;
        holds_done = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            // long hold-offs so the block backs up and stalls s_ready
            if ((holds_done == 0 && book.checked >= 150) ||
                (holds_done == 1 && book.checked >= 900)) begin
                holds_done++;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 20);
            m_ready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            stall_len = idle_len();
            if (stall_len != 0) begin
                m_ready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            book.check_result(m_status, m_owner_valid, m_owner_id, m_waiters);
    end

    initial begin : watchdog
        #1_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
